// File: rtl/touch_report_decode_calibrate_assert.svh
// assertion macros shared by the touch report decoder rtl
`ifndef TOUCH_REPORT_DECODE_CALIBRATE_ASSERT_SVH
`define TOUCH_REPORT_DECODE_CALIBRATE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define TRDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("touch report decode assertion failed");
// next-cycle implication, checked out of reset
`define TRDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch report decode assertion failed");
`else
`define TRDC_ASSERT_NOW(lbl, ante, cons)
`define TRDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/trdc_pkg.sv
// types, widths and calibration coefficients for the touch report decoder
`default_nettype none
package trdc_pkg;

  // fixed point and datapath widths
  localparam int FRAC_BITS = 40;
  localparam int X_W       = 12;
  localparam int OUT_X_W   = 16;
  localparam int ACC_W     = 88;
  localparam int LANE_W    = 32;
  localparam int HI_W      = ACC_W - 2 * LANE_W;
  localparam int PL_W      = LANE_W + X_W;
  localparam int PH_W      = HI_W + X_W + 1;
  localparam int ORDER     = 4;
  localparam int NSTG      = 2 * ORDER + 2;
  localparam int WIDE_W    = 128;

  // input report transfer
  typedef struct packed {
    logic       touch_pending;
    logic       bus_error;
    logic [7:0] count_byte;
    logic [7:0] x_high_byte;
    logic [7:0] x_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] y_low_byte;
  } in_t;

  // decoded result transfer
  typedef struct packed {
    logic               touch_valid;
    logic [OUT_X_W-1:0] x_corrected;
    logic [X_W-1:0]     y_position;
  } out_t;

  // coefficient = mant / 10^dexp, rounded to nearest, ties away from zero
  function automatic logic signed [ACC_W-1:0] coef_fixed(input logic [63:0] mant,
                                                         input int unsigned dexp,
                                                         input logic neg);
    logic [WIDE_W-1:0] v;
    v = WIDE_W'(mant) << (FRAC_BITS + 1);
    for (int unsigned i = 0; i < dexp; i++) begin
      v = v / 10;
    end
    v = (v + WIDE_W'(1)) >> 1;
    if (neg) begin
      v = -v;
    end
    return v[ACC_W-1:0];
  endfunction

  // index is the power of x
  localparam logic signed [ACC_W-1:0] COEF [ORDER+1] = '{
    coef_fixed(64'd136130873481304, 13, 1'b1),
    coef_fixed(64'd103180366959475, 14, 1'b0),
    coef_fixed(64'd157472407213897, 17, 1'b1),
    coef_fixed(64'd201591939009656, 19, 1'b0),
    coef_fixed(64'd47145716844327,  21, 1'b1)
  };

endpackage
`default_nettype wire

// File: rtl/touch_report_decode_calibrate.sv
// touch report decoder with pipelined quartic x calibration
// each result passes a decode stage, the round stages and an output register
// throughput: one report per cycle; four multiply/add round pairs in horner form
// each round splits the accumulator into three lanes multiplied by x, then sums
// the whole pipeline holds while a result waits and out_ready is low
// reset (rst_n low, synchronous) empties every stage; no other state is kept
`default_nettype none
`include "touch_report_decode_calibrate_assert.svh"
module touch_report_decode_calibrate (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output                     logic in_ready,
  input  wire  trdc_pkg::in_t      in_data,
  output                     logic out_valid,
  input  wire                logic out_ready,
  output       trdc_pkg::out_t     out_data
);

  localparam int NSTG  = trdc_pkg::NSTG;
  localparam int ORDER = trdc_pkg::ORDER;
  localparam int ACC_W = trdc_pkg::ACC_W;
  localparam int LW    = trdc_pkg::LANE_W;
  localparam int HW    = trdc_pkg::HI_W;
  localparam int XW    = trdc_pkg::X_W;
  localparam int FB    = trdc_pkg::FRAC_BITS;
  localparam int OXW   = trdc_pkg::OUT_X_W;

  logic                    en;
  logic [NSTG-1:0]         vld_r;
  logic                    tv_r [NSTG-1];
  logic [XW-1:0]           x_r  [NSTG-2];
  logic [XW-1:0]           y_r  [NSTG-1];
  logic signed [ACC_W-1:0] acc_r   [ORDER+1];
  logic signed [ACC_W-1:0] acc_nxt [ORDER];
  logic [trdc_pkg::PL_W-1:0]        pp_lo_r  [ORDER];
  logic [trdc_pkg::PL_W-1:0]        pp_mid_r [ORDER];
  logic signed [trdc_pkg::PH_W-1:0] pp_hi_r  [ORDER];
  logic                    dec_valid;
  trdc_pkg::out_t          out_nxt;
  trdc_pkg::out_t          out_data_r;

  // whole pipeline advances when the output register is free or drained
  assign en        = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_data_r;

  // report is a touch when pending, bus clean and count nonzero
  assign dec_valid = in_data.touch_pending && !in_data.bus_error &&
                     (in_data.count_byte != 8'd0);

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // decode stage and side-band shift line
  always_ff @(posedge clk) begin
    if (en) begin
      tv_r[0]  <= dec_valid;
      x_r[0]   <= {in_data.x_high_byte[3:0], in_data.x_low_byte};
      y_r[0]   <= {in_data.y_high_byte[3:0], in_data.y_low_byte};
      acc_r[0] <= trdc_pkg::COEF[ORDER];
      for (int i = 1; i < NSTG - 1; i++) begin
        tv_r[i] <= tv_r[i-1];
        y_r[i]  <= y_r[i-1];
      end
      for (int i = 1; i < NSTG - 2; i++) begin
        x_r[i] <= x_r[i-1];
      end
    end
  end

  // horner rounds: multiply stage then accumulate stage
  for (genvar r = 0; r < ORDER; r++) begin : g_round
    // lane products of the accumulator by x
    always_ff @(posedge clk) begin
      if (en) begin
        pp_lo_r[r]  <= acc_r[r][LW-1:0] * x_r[2*r];
        pp_mid_r[r] <= acc_r[r][2*LW-1:LW] * x_r[2*r];
        pp_hi_r[r]  <= $signed(acc_r[r][ACC_W-1:2*LW]) * $signed({1'b0, x_r[2*r]});
      end
    end

    // recombine lanes modulo the accumulator width and add the next coefficient
    always_comb begin
      acc_nxt[r] = {pp_hi_r[r][HW-1:0], {(2*LW){1'b0}}}
                 + {{(ACC_W-LW-trdc_pkg::PL_W){1'b0}}, pp_mid_r[r], {LW{1'b0}}}
                 + {{(ACC_W-trdc_pkg::PL_W){1'b0}}, pp_lo_r[r]}
                 + trdc_pkg::COEF[ORDER-1-r];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[r+1] <= acc_nxt[r];
      end
    end
  end

  // truncate the fraction, clamp to the 16-bit range, blank invalid reports
  always_comb begin
    out_nxt = '0;
    if (tv_r[NSTG-2]) begin
      out_nxt.touch_valid = 1'b1;
      out_nxt.y_position  = y_r[NSTG-2];
      if (acc_r[ORDER][ACC_W-1]) begin
        out_nxt.x_corrected = '0;
      end else if (acc_r[ORDER][ACC_W-2:FB+OXW] != '0) begin
        out_nxt.x_corrected = '1;
      end else begin
        out_nxt.x_corrected = acc_r[ORDER][FB+OXW-1:FB];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  // a result that is not a touch carries zero coordinates
  `TRDC_ASSERT_NOW(a_blank_invalid, out_valid && !out_data.touch_valid,
    (out_data.x_corrected == '0) && (out_data.y_position == '0))
  // a held output freezes every stage
  `TRDC_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, $stable(vld_r))
  // leaving reset the pipeline is empty
  `TRDC_ASSERT_NOW(a_reset_empty, $past(!rst_n), vld_r == '0)

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for the touch report decoder with x calibration
`timescale 1ns / 1ps
module testbench;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_PRINTS = 60;

  // expected coordinates for accepted reports, checked in order
  class coord_scoreboard;
    logic signed [127:0] poly_coef [5];
    trdc_pkg::out_t awaited [$];
    int fails;

    function new();
      fails = 0;
      poly_coef[0] = fixed_coef(64'd136130873481304, 13, 1'b1);
      poly_coef[1] = fixed_coef(64'd103180366959475, 14, 1'b0);
      poly_coef[2] = fixed_coef(64'd157472407213897, 17, 1'b1);
      poly_coef[3] = fixed_coef(64'd201591939009656, 19, 1'b0);
      poly_coef[4] = fixed_coef(64'd47145716844327, 21, 1'b1);
    endfunction

    // mant / 10^dexp in fixed point, nearest with ties away from zero
    function logic signed [127:0] fixed_coef(logic [63:0] mant, int dexp, bit neg);
      logic [127:0] mag;
      logic [127:0] div;
      mag = 128'(mant) << (trdc_pkg::FRAC_BITS + 1);
      div = 128'd1;
      repeat (dexp) div = div * 128'd10;
      mag = ((mag / div) + 128'd1) >> 1;
      return neg ? -mag : mag;
    endfunction

    // quartic in horner form, exact; truncate and clamp to 0..65535
    function logic [15:0] calibrated_x(logic [11:0] x);
      logic signed [127:0] acc;
      logic signed [127:0] xw;
      logic [127:0] whole;
      xw = {116'd0, x};
      acc = poly_coef[4];
      for (int i = 3; i >= 0; i--) acc = acc * xw + poly_coef[i];
      if (acc[127]) return 16'd0;
      whole = acc >> trdc_pkg::FRAC_BITS;
      if (whole > 128'd65535) return 16'hffff;
      return whole[15:0];
    endfunction

    function trdc_pkg::out_t decode_report(trdc_pkg::in_t r);
      trdc_pkg::out_t o;
      o = '0;
      if (r.touch_pending && !r.bus_error && r.count_byte != 8'd0) begin
        o.touch_valid = 1'b1;
        o.x_corrected = calibrated_x({r.x_high_byte[3:0], r.x_low_byte});
        o.y_position = {r.y_high_byte[3:0], r.y_low_byte};
      end
      return o;
    endfunction

    task report(string what);
      fails++;
      if (fails <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function void note_report(trdc_pkg::in_t r);
      awaited.push_back(decode_report(r));
    endfunction

    task check_coords(trdc_pkg::out_t got);
      trdc_pkg::out_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with no report waiting (%h)", got));
        return;
      end
      want = awaited.pop_front();
      if (got.touch_valid !== want.touch_valid)
        report($sformatf("touch_valid %b, expected %b", got.touch_valid, want.touch_valid));
      if (got.x_corrected !== want.x_corrected)
        report($sformatf("x_corrected %0d, expected %0d", got.x_corrected,
                         want.x_corrected));
      if (got.y_position !== want.y_position)
        report($sformatf("y_position %0d, expected %0d", got.y_position, want.y_position));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  trdc_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  trdc_pkg::out_t out_data;

  coord_scoreboard sb = new();
  int sender_idle_pct;
  bit quiet;
  bit hold_off_req;
  bit holding;

  touch_report_decode_calibrate dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watch both channels at each edge, using pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_report(in_data);
      if (out_valid && out_ready) sb.check_coords(out_data);
    end
  end

  // result side: random ready bursts, one long hold-off, steady at the end
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (hold_off_req) begin
        holding = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        holding = 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  function automatic trdc_pkg::in_t make_report(bit p, bit e, logic [7:0] cnt,
                                                logic [7:0] xh, logic [7:0] xl,
                                                logic [7:0] yh, logic [7:0] yl);
    trdc_pkg::in_t r;
    r.touch_pending = p;
    r.bus_error = e;
    r.count_byte = cnt;
    r.x_high_byte = xh;
    r.x_low_byte = xl;
    r.y_high_byte = yh;
    r.y_low_byte = yl;
    return r;
  endfunction

  // mostly well-formed touches, x often near the zero crossings of the curve
  function automatic trdc_pkg::in_t random_report();
    trdc_pkg::in_t r;
    logic [63:0] raw;
    logic [11:0] xv;
    raw = {$urandom, $urandom};
    r = raw[$bits(trdc_pkg::in_t)-1:0];
    if ($urandom_range(0, 99) < 75) begin
      r.touch_pending = 1'b1;
      r.bus_error = 1'b0;
      if (r.count_byte == 8'd0) r.count_byte = 8'd1;
    end
    xv = {r.x_high_byte[3:0], r.x_low_byte};
    case ($urandom_range(0, 3))
      0: xv = 12'($urandom_range(0, 600));
      1: xv = 12'($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(460, 520));
      default: ;
    endcase
    r.x_high_byte[3:0] = xv[11:8];
    r.x_low_byte = xv[7:0];
    return r;
  endfunction

  // optional idle burst before the next report
  task sender_gap();
    if (!quiet && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // hold the report until the block takes it
  task offer_report(trdc_pkg::in_t r);
    sender_gap();
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task wait_for_drain();
    int guard;
    guard = 0;
    while (sb.awaited.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // reset, then directed, random, hold-off and steady phases
  initial begin
    trdc_pkg::in_t directed [$];
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    sender_idle_pct = 20;
    quiet = 1'b0;
    hold_off_req = 1'b0;
    holding = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rejected reports
    directed.push_back(make_report(1'b0, 1'b0, 8'd1, 8'h00, 8'd100, 8'h00, 8'd50));
    directed.push_back(make_report(1'b1, 1'b1, 8'd1, 8'h01, 8'h00, 8'h02, 8'h00));
    directed.push_back(make_report(1'b1, 1'b0, 8'd0, 8'h01, 8'h00, 8'h02, 8'h00));
    directed.push_back(make_report(1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_report(1'b0, 1'b0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    directed.push_back(make_report(1'b1, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    directed.push_back(make_report(1'b0, 1'b1, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff));
    // count extremes and coordinate extremes
    directed.push_back(make_report(1'b1, 1'b0, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_report(1'b1, 1'b0, 8'hff, 8'h0f, 8'hff, 8'h0f, 8'hff));
    // upper nibbles ignored
    directed.push_back(make_report(1'b1, 1'b0, 8'h80, 8'hff, 8'hff, 8'hff, 8'hff));
    directed.push_back(make_report(1'b1, 1'b0, 8'h02, 8'hf0, 8'h00, 8'hf0, 8'h00));
    directed.push_back(make_report(1'b1, 1'b0, 8'h03, 8'ha0, 8'ha5, 8'h55, 8'ha5));
    // around the low zero crossing, the peak and the high zero crossing
    directed.push_back(make_report(1'b1, 1'b0, 8'd1, 8'h00, 8'd13, 8'h01, 8'h23));
    directed.push_back(make_report(1'b1, 1'b0, 8'd1, 8'h00, 8'd14, 8'h04, 8'h56));
    directed.push_back(make_report(1'b1, 1'b0, 8'd1, 8'h00, 8'd15, 8'h07, 8'h89));
    directed.push_back(make_report(1'b1, 1'b0, 8'd5, 8'h01, 8'h2c, 8'h0a, 8'hbc));
    directed.push_back(make_report(1'b1, 1'b0, 8'd5, 8'h01, 8'h5e, 8'h0d, 8'hef));
    directed.push_back(make_report(1'b1, 1'b0, 8'd5, 8'h01, 8'he0, 8'h00, 8'h01));
    directed.push_back(make_report(1'b1, 1'b0, 8'd5, 8'h01, 8'he1, 8'h0f, 8'hfe));
    directed.push_back(make_report(1'b1, 1'b0, 8'd5, 8'h01, 8'hf4, 8'h08, 8'h00));
    directed.push_back(make_report(1'b1, 1'b0, 8'd9, 8'h03, 8'he8, 8'h07, 8'hff));
    directed.push_back(make_report(1'b1, 1'b0, 8'd9, 8'h08, 8'h00, 8'h08, 8'h00));
    foreach (directed[i]) offer_report(directed[i]);

    // random reports with sender idling switched on and off in blocks
    for (int i = 0; i < 200; i++) begin
      if (i % 25 == 0) sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
      offer_report(random_report());
    end

    // receiver holds off while reports keep coming, so the pipeline backs up
    sender_idle_pct = 0;
    in_valid <= 1'b0;
    hold_off_req = 1'b1;
    while (!holding) @(posedge clk);
    for (int i = 0; i < 60; i++) offer_report(random_report());

    // pause until every result is back
    in_valid <= 1'b0;
    wait_for_drain();

    for (int i = 0; i < 190; i++) begin
      if (i % 25 == 0) sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
      offer_report(random_report());
    end

    // steady traffic with no idling on either side
    quiet = 1'b1;
    for (int i = 0; i < 80; i++) offer_report(random_report());
    in_valid <= 1'b0;

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
